FILE: sv/tcw_pkg.sv
// Shared types and constants of the text console writer.
`default_nettype none

package tcw_pkg;

    localparam int DEF_COLUMNS = 80;
    localparam int DEF_ROWS    = 25;

    localparam int OPCODE_W  = 2;
    localparam int CHAR_W    = 8;
    localparam int COLOR_W   = 8;
    localparam int NIBBLE_W  = 4;
    localparam int INDEX_W   = 11;
    localparam int ROW_OUT_W = 5;
    localparam int COL_OUT_W = 7;
    localparam int CFG_IDX_W = 1;
    localparam int CELL_W    = COLOR_W + CHAR_W;

    localparam logic [CHAR_W-1:0]   NEWLINE_CODE = 8'd10;
    localparam logic [CHAR_W-1:0]   SPACE_CODE   = 8'd32;
    localparam logic [NIBBLE_W-1:0] RESET_FG     = 4'hF;
    localparam logic [NIBBLE_W-1:0] RESET_BG     = 4'h0;

    typedef enum logic [OPCODE_W-1:0] {
        OP_PUT   = 2'd0,
        OP_CLEAR = 2'd1,
        OP_READ  = 2'd2
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FG = 1'b0,
        CFG_BG = 1'b1
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_READ,
        ST_SCROLL,
        ST_BLANK,
        ST_PUT
    } state_t;

    typedef struct packed {
        logic we;
        logic re;
    } mem_ctl_t;

endpackage

`default_nettype wire

FILE: sv/tcw_screen_mem.sv
// Screen cell memory: one write port, one read port, registered read data.
`default_nettype none

module tcw_screen_mem #(
    parameter int DEPTH  = tcw_pkg::DEF_COLUMNS * tcw_pkg::DEF_ROWS,
    parameter int ADDR_W = $clog2(tcw_pkg::DEF_COLUMNS * tcw_pkg::DEF_ROWS)
) (
    input  logic                        clk,
    input  tcw_pkg::mem_ctl_t           mem_ctl,
    input  logic [ADDR_W-1:0]           waddr,
    input  logic [tcw_pkg::CELL_W-1:0]  wdata,
    input  logic [ADDR_W-1:0]           raddr,
    output logic [tcw_pkg::CELL_W-1:0]  rdata
);
    import tcw_pkg::*;

    logic [CELL_W-1:0] mem [DEPTH];
    logic [CELL_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (mem_ctl.we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_ctl.re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: sv/tcw_ctrl.sv
// Request sequencer: cursor, scroll copy, fill sweeps and cell read-back.
`default_nettype none

module tcw_ctrl #(
    parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
    parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        start,
    input  logic [tcw_pkg::OPCODE_W-1:0]                opcode,
    input  logic [tcw_pkg::CHAR_W-1:0]                  char_code,
    input  logic [tcw_pkg::INDEX_W-1:0]                 cell_index,
    input  logic [tcw_pkg::COLOR_W-1:0]                 color,
    output logic                                        busy,
    output logic                                        done,
    output logic [tcw_pkg::CHAR_W-1:0]                  cell_char,
    output logic [tcw_pkg::COLOR_W-1:0]                 cell_color,
    output logic [$clog2(ROWS)-1:0]                     cursor_line,
    output logic [$clog2(COLUMNS+1)-1:0]                cursor_column,
    output tcw_pkg::mem_ctl_t                           mem_ctl,
    output logic [$clog2(ROWS*COLUMNS)-1:0]             mem_waddr,
    output logic [tcw_pkg::CELL_W-1:0]                  mem_wdata,
    output logic [$clog2(ROWS*COLUMNS)-1:0]             mem_raddr,
    input  logic [tcw_pkg::CELL_W-1:0]                  mem_rdata
);
    import tcw_pkg::*;

    localparam int CELLS         = ROWS * COLUMNS;
    localparam int ADDR_W        = $clog2(CELLS);
    localparam int CNT_W         = $clog2(CELLS + 1);
    localparam int ROW_W         = $clog2(ROWS);
    localparam int COL_W         = $clog2(COLUMNS + 1);
    localparam int LAST_ROW_BASE = (ROWS - 1) * COLUMNS;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [ROW_W-1:0]    line_reg, line_next;
    logic [COL_W-1:0]    col_reg, col_next;
    logic [ADDR_W-1:0]   base_reg, base_next;
    logic                pend_reg, pend_next;
    logic                done_reg, done_next;
    logic [CHAR_W-1:0]   char_reg, char_next;
    logic [CHAR_W-1:0]   cell_char_reg, cell_char_next;
    logic [COLOR_W-1:0]  cell_color_reg, cell_color_next;

    logic                     accept;
    logic                     last_row;
    logic                     in_range;
    logic [ADDR_W-1:0]        put_addr;
    logic [ADDR_W-1:0]        down_base;
    logic [ADDR_W+INDEX_W-1:0] idx_ext;
    logic [CNT_W-1:0]         copy_dst;

    assign accept    = start && (state_reg == ST_IDLE);
    assign last_row  = (line_reg == ROW_W'(ROWS - 1));
    assign in_range  = ({21'd0, cell_index} < 32'(CELLS));
    assign put_addr  = base_reg + ADDR_W'(col_reg);
    assign down_base = base_reg + ADDR_W'(COLUMNS);
    assign idx_ext   = {{ADDR_W{1'b0}}, cell_index};
    assign copy_dst  = cnt_reg - CNT_W'(COLUMNS + 1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
            cnt_reg   <= '0;
            line_reg  <= '0;
            col_reg   <= '0;
            base_reg  <= '0;
            pend_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            line_reg  <= line_next;
            col_reg   <= col_next;
            base_reg  <= base_next;
            pend_reg  <= pend_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        char_reg       <= char_next;
        cell_char_reg  <= cell_char_next;
        cell_color_reg <= cell_color_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        line_next       = line_reg;
        col_next        = col_reg;
        base_next       = base_reg;
        pend_next       = pend_reg;
        done_next       = 1'b0;
        char_next       = char_reg;
        cell_char_next  = '0;
        cell_color_next = '0;
        mem_ctl         = '0;
        mem_waddr       = cnt_reg[ADDR_W-1:0];
        mem_wdata       = {color, SPACE_CODE};
        mem_raddr       = cnt_reg[ADDR_W-1:0];

        unique case (state_reg)
            ST_INIT:
            begin
                mem_ctl.we = 1'b1;
                mem_wdata  = {RESET_BG, RESET_FG, SPACE_CODE};
                if (cnt_reg == CNT_W'(CELLS - 1))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end

            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (opcode)
                        OP_PUT:
                        begin
                            if (char_code == NEWLINE_CODE)
                            begin
                                col_next = '0;
                                if (!last_row)
                                begin
                                    line_next = line_reg + 1'b1;
                                    base_next = down_base;
                                    done_next = 1'b1;
                                end
                                else
                                begin
                                    pend_next  = 1'b0;
                                    cnt_next   = CNT_W'(COLUMNS);
                                    state_next = ST_SCROLL;
                                end
                            end
                            else if (col_reg >= COL_W'(COLUMNS))
                            begin
                                // wrap pending: newline first, then place at column 0
                                if (!last_row)
                                begin
                                    line_next  = line_reg + 1'b1;
                                    base_next  = down_base;
                                    mem_ctl.we = 1'b1;
                                    mem_waddr  = down_base;
                                    mem_wdata  = {color, char_code};
                                    col_next   = COL_W'(1);
                                    done_next  = 1'b1;
                                end
                                else
                                begin
                                    char_next  = char_code;
                                    pend_next  = 1'b1;
                                    col_next   = '0;
                                    cnt_next   = CNT_W'(COLUMNS);
                                    state_next = ST_SCROLL;
                                end
                            end
                            else
                            begin
                                mem_ctl.we = 1'b1;
                                mem_waddr  = put_addr;
                                mem_wdata  = {color, char_code};
                                col_next   = col_reg + 1'b1;
                                done_next  = 1'b1;
                            end
                        end

                        OP_CLEAR:
                        begin
                            pend_next  = 1'b0;
                            cnt_next   = '0;
                            state_next = ST_BLANK;
                        end

                        OP_READ:
                        begin
                            if (in_range)
                            begin
                                mem_ctl.re = 1'b1;
                                mem_raddr  = idx_ext[ADDR_W-1:0];
                                state_next = ST_READ;
                            end
                            else
                            begin
                                done_next = 1'b1;
                            end
                        end

                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end

            ST_READ:
            begin
                cell_char_next  = mem_rdata[CHAR_W-1:0];
                cell_color_next = mem_rdata[CELL_W-1:CHAR_W];
                done_next       = 1'b1;
                state_next      = ST_IDLE;
            end

            ST_SCROLL:
            begin
                // read one row ahead, write back the cell read last cycle
                mem_ctl.re = (cnt_reg != CNT_W'(CELLS));
                mem_ctl.we = (cnt_reg != CNT_W'(COLUMNS));
                mem_waddr  = copy_dst[ADDR_W-1:0];
                mem_wdata  = mem_rdata;
                if (cnt_reg == CNT_W'(CELLS))
                begin
                    cnt_next   = CNT_W'(LAST_ROW_BASE);
                    state_next = ST_BLANK;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end

            ST_BLANK:
            begin
                mem_ctl.we = 1'b1;
                if (cnt_reg == CNT_W'(CELLS - 1))
                begin
                    if (pend_reg)
                    begin
                        state_next = ST_PUT;
                    end
                    else
                    begin
                        done_next  = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end

            ST_PUT:
            begin
                mem_ctl.we = 1'b1;
                mem_waddr  = base_reg;
                mem_wdata  = {color, char_reg};
                col_next   = COL_W'(1);
                pend_next  = 1'b0;
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy          = (state_reg != ST_IDLE);
    assign done          = done_reg;
    assign cell_char     = cell_char_reg;
    assign cell_color    = cell_color_reg;
    assign cursor_line   = line_reg;
    assign cursor_column = col_reg;

endmodule

`default_nettype wire

FILE: sv/text_console_writer_core.sv
// Top level of the text console writer: color registers, sequencer and screen memory.
//
// A request (put character, clear screen, read cell) is taken when start is
// high and busy is low; exactly one result follows, marked by a one-cycle
// done strobe that cannot be held off. Putting a character or a newline that
// does not scroll, and an unused opcode or an out-of-range read, give the
// result in the cycle after the request; an in-range read passes through the
// READ state first. All screen traffic goes through the single write port of
// the cell memory: a newline on the last row (or a character that wraps there)
// walks the memory to shift rows up, then blanks the bottom row (and then
// places a wrapped character), and a clear blanks every cell. After reset,
// busy stays high while every cell is filled with a white-on-black space;
// color writes are taken at any time.
`default_nettype none

module text_console_writer_core #(
    parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
    parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [tcw_pkg::OPCODE_W-1:0]      opcode,
    input  logic [tcw_pkg::CHAR_W-1:0]        char_code,
    input  logic [tcw_pkg::INDEX_W-1:0]       cell_index,
    output logic                              done,
    output logic [tcw_pkg::CHAR_W-1:0]        cell_char,
    output logic [tcw_pkg::COLOR_W-1:0]       cell_color,
    output logic [tcw_pkg::ROW_OUT_W-1:0]     cursor_row,
    output logic [tcw_pkg::COL_OUT_W-1:0]     cursor_col,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [tcw_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tcw_pkg::NIBBLE_W-1:0]      cfg_data
);
    import tcw_pkg::*;

    localparam int CELLS  = ROWS * COLUMNS;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int COL_W  = $clog2(COLUMNS + 1);

    logic [NIBBLE_W-1:0] fg_reg, fg_next;
    logic [NIBBLE_W-1:0] bg_reg, bg_next;

    mem_ctl_t            mem_ctl;
    logic [ADDR_W-1:0]   mem_waddr;
    logic [ADDR_W-1:0]   mem_raddr;
    logic [CELL_W-1:0]   mem_wdata;
    logic [CELL_W-1:0]   mem_rdata;
    logic [ROW_W-1:0]    line;
    logic [COL_W-1:0]    column;

    logic [ROW_W+ROW_OUT_W-1:0] row_ext;
    logic [COL_W+COL_OUT_W-1:0] col_ext;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        fg_next = fg_reg;
        bg_next = bg_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_FG:  fg_next = cfg_data;
                CFG_BG:  bg_next = cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fg_reg <= RESET_FG;
            bg_reg <= RESET_BG;
        end
        else
        begin
            fg_reg <= fg_next;
            bg_reg <= bg_next;
        end
    end

    tcw_ctrl #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .opcode        (opcode),
        .char_code     (char_code),
        .cell_index    (cell_index),
        .color         ({bg_reg, fg_reg}),
        .busy          (busy),
        .done          (done),
        .cell_char     (cell_char),
        .cell_color    (cell_color),
        .cursor_line   (line),
        .cursor_column (column),
        .mem_ctl       (mem_ctl),
        .mem_waddr     (mem_waddr),
        .mem_wdata     (mem_wdata),
        .mem_raddr     (mem_raddr),
        .mem_rdata     (mem_rdata)
    );

    tcw_screen_mem #(
        .DEPTH  (CELLS),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .clk     (clk),
        .mem_ctl (mem_ctl),
        .waddr   (mem_waddr),
        .wdata   (mem_wdata),
        .raddr   (mem_raddr),
        .rdata   (mem_rdata)
    );

    // fit the cursor to the fixed port widths: zero-extend or drop high bits
    assign row_ext    = {{ROW_OUT_W{1'b0}}, line};
    assign col_ext    = {{COL_OUT_W{1'b0}}, column};
    assign cursor_row = row_ext[ROW_OUT_W-1:0];
    assign cursor_col = col_ext[COL_OUT_W-1:0];

endmodule

`default_nettype wire

FILE: sv/tcw_checker.sv
// Port-level checks of the text console writer and their bind.
`default_nettype none

module tcw_checker #(
    parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
    parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              start,
    input wire logic                              busy,
    input wire logic [tcw_pkg::OPCODE_W-1:0]      opcode,
    input wire logic [tcw_pkg::CHAR_W-1:0]        char_code,
    input wire logic                              done,
    input wire logic [tcw_pkg::CHAR_W-1:0]        cell_char,
    input wire logic [tcw_pkg::COLOR_W-1:0]       cell_color,
    input wire logic [tcw_pkg::ROW_OUT_W-1:0]     cursor_row,
    input wire logic [tcw_pkg::COL_OUT_W-1:0]     cursor_col
);
    import tcw_pkg::*;

    logic req_accept;
    assign req_accept = start && !busy;

    // a result always leaves the block ready for the next request
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    // cursor column never passes the pending-wrap position
    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        ({25'd0, cursor_col} <= COLUMNS))
        else $error("cursor column out of range");

    // cursor row always names a row of the screen
    a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
        ({27'd0, cursor_row} < ROWS))
        else $error("cursor row out of range");

    // unused opcode answers at once with empty cell data
    a_unused_op: assert property (@(posedge clk) disable iff (!rst_n)
        (req_accept && opcode != OP_PUT && opcode != OP_CLEAR && opcode != OP_READ)
        |=> (done && cell_char == '0 && cell_color == '0))
        else $error("unused opcode result wrong");

    // a printable character with room on the row advances the column by one
    a_put_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (req_accept && opcode == OP_PUT && char_code != NEWLINE_CODE
         && (COLUMNS < 128) && ({25'd0, cursor_col} < COLUMNS))
        |=> (done && cursor_col == $past(cursor_col) + 7'd1
             && cursor_row == $past(cursor_row)))
        else $error("put character did not advance cursor");

endmodule

bind text_console_writer_core tcw_checker #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
) u_tcw_checker (.*);

`default_nettype wire

FILE: tb/testbench.sv
// Testbench for the text console writer: directed requests, random traffic, shadow-screen check.
`timescale 1ns / 100ps

module testbench;

    import tcw_pkg::*;

    localparam int COLS  = DEF_COLUMNS;
    localparam int LINES = DEF_ROWS;
    localparam int CELLS = COLS * LINES;

    localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [CHAR_W-1:0]    cell_char;
        logic [COLOR_W-1:0]   cell_color;
        logic [ROW_OUT_W-1:0] cursor_row;
        logic [COL_OUT_W-1:0] cursor_col;
    } console_result_t;

    typedef struct packed {
        logic [OPCODE_W-1:0] op;
        logic [CHAR_W-1:0]   ch;
        logic [INDEX_W-1:0]  idx;
        logic                typed;
        console_result_t     want;
    } stim_row_t;

    localparam console_result_t NO_READ = '0;

    localparam int DIRECTED_ROWS = 21;
    localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
        '{OP_READ,   8'd0,         11'd0,    1'b1, '{SPACE_CODE, 8'h0F, 5'd0, 7'd0}},
        '{OP_READ,   8'd0,         11'd1999, 1'b1, '{SPACE_CODE, 8'h0F, 5'd0, 7'd0}},
        '{OP_READ,   8'd0,         11'd2000, 1'b1, NO_READ},
        '{OP_READ,   8'hFF,        11'd2047, 1'b1, NO_READ},
        '{OP_UNUSED, 8'hFF,        11'd2047, 1'b1, NO_READ},
        '{OP_PUT,    8'd65,        11'd0,    1'b1, '{8'd0, 8'd0, 5'd0, 7'd1}},
        '{OP_PUT,    8'hFF,        11'h7FF,  1'b1, '{8'd0, 8'd0, 5'd0, 7'd2}},
        '{OP_PUT,    8'h00,        11'd0,    1'b1, '{8'd0, 8'd0, 5'd0, 7'd3}},
        '{OP_READ,   8'd0,         11'd1,    1'b1, '{8'hFF, 8'h0F, 5'd0, 7'd3}},
        '{OP_READ,   8'd0,         11'd2,    1'b1, '{8'h00, 8'h0F, 5'd0, 7'd3}},
        '{OP_PUT,    NEWLINE_CODE, 11'd0,    1'b1, '{8'd0, 8'd0, 5'd1, 7'd0}},
        '{OP_PUT,    SPACE_CODE,   11'd0,    1'b1, '{8'd0, 8'd0, 5'd1, 7'd1}},
        '{OP_PUT,    NEWLINE_CODE, 11'd0,    1'b1, '{8'd0, 8'd0, 5'd2, 7'd0}},
        '{OP_PUT,    NEWLINE_CODE, 11'd0,    1'b1, '{8'd0, 8'd0, 5'd3, 7'd0}},
        '{OP_READ,   8'd0,         11'd80,   1'b0, NO_READ},
        '{OP_CLEAR,  8'd0,         11'd0,    1'b1, '{8'd0, 8'd0, 5'd3, 7'd0}},
        '{OP_READ,   8'd0,         11'd0,    1'b1, '{SPACE_CODE, 8'h0F, 5'd3, 7'd0}},
        '{OP_PUT,    8'd90,        11'd0,    1'b1, '{8'd0, 8'd0, 5'd3, 7'd1}},
        '{OP_READ,   8'd0,         11'd240,  1'b1, '{8'd90, 8'h0F, 5'd3, 7'd1}},
        '{OP_READ,   8'd0,         11'd1999, 1'b0, NO_READ},
        '{OP_UNUSED, 8'd0,         11'd0,    1'b1, '{8'd0, 8'd0, 5'd3, 7'd1}}
    };

    logic                   clk;
    logic                   rst_n;
    logic                   start;
    logic                   busy;
    logic [OPCODE_W-1:0]    opcode;
    logic [CHAR_W-1:0]      char_code;
    logic [INDEX_W-1:0]     cell_index;
    logic                   done;
    logic [CHAR_W-1:0]      cell_char;
    logic [COLOR_W-1:0]     cell_color;
    logic [ROW_OUT_W-1:0]   cursor_row;
    logic [COL_OUT_W-1:0]   cursor_col;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [NIBBLE_W-1:0]    cfg_data;

    // shadow of the screen, cursor and color registers
    logic [CHAR_W-1:0]   shadow_chr [CELLS];
    logic [COLOR_W-1:0]  shadow_clr [CELLS];
    int                  cur_line;
    int                  cur_col;
    logic [NIBBLE_W-1:0] fg_nib;
    logic [NIBBLE_W-1:0] bg_nib;

    console_result_t pending_results [$];
    int              error_count;
    int              issued_count;
    bit              gapless;

    text_console_writer_core #(
        .COLUMNS (COLS),
        .ROWS    (LINES)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .opcode     (opcode),
        .char_code  (char_code),
        .cell_index (cell_index),
        .done       (done),
        .cell_char  (cell_char),
        .cell_color (cell_color),
        .cursor_row (cursor_row),
        .cursor_col (cursor_col),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    function automatic logic [COLOR_W-1:0] paint_color();
        return {bg_nib, fg_nib};
    endfunction

    task automatic blank_line(input int line);
        int i;
        begin
            for (i = 0; i < COLS; i++)
            begin
                shadow_chr[line * COLS + i] = SPACE_CODE;
                shadow_clr[line * COLS + i] = paint_color();
            end
        end
    endtask

    task automatic advance_line();
        int i;
        begin
            cur_col = 0;
            if (cur_line < LINES - 1)
            begin
                cur_line++;
            end
            else
            begin
                // scroll: shift every row up and blank the bottom one
                for (i = 0; i < CELLS - COLS; i++)
                begin
                    shadow_chr[i] = shadow_chr[i + COLS];
                    shadow_clr[i] = shadow_clr[i + COLS];
                end
                blank_line(LINES - 1);
            end
        end
    endtask

    task automatic render_request(input logic [OPCODE_W-1:0] op, input logic [CHAR_W-1:0] ch,
                                  input logic [INDEX_W-1:0] idx, output console_result_t res);
        int pos;
        int r;
        begin
            res = '0;
            case (op)
                OP_PUT:
                begin
                    if (ch == NEWLINE_CODE)
                    begin
                        advance_line();
                    end
                    else
                    begin
                        // deferred wrap: a full line takes a newline first
                        if (cur_col >= COLS)
                        begin
                            advance_line();
                        end
                        pos = cur_line * COLS + cur_col;
                        if (pos < CELLS)
                        begin
                            shadow_chr[pos] = ch;
                            shadow_clr[pos] = paint_color();
                        end
                        cur_col++;
                    end
                end
                OP_CLEAR:
                begin
                    for (r = 0; r < LINES; r++)
                    begin
                        blank_line(r);
                    end
                end
                OP_READ:
                begin
                    if (idx < CELLS)
                    begin
                        res.cell_char  = shadow_chr[idx];
                        res.cell_color = shadow_clr[idx];
                    end
                end
                default:
                begin
                end
            endcase
            res.cursor_row = cur_line[ROW_OUT_W-1:0];
            res.cursor_col = cur_col[COL_OUT_W-1:0];
        end
    endtask

    function automatic int pick_gap();
        int roll;
        begin
            roll = $urandom_range(0, 99);
            if (gapless || roll < 65)
            begin
                return 0;
            end
            if (roll < 92)
            begin
                return $urandom_range(1, 3);
            end
            return $urandom_range(6, 40);
        end
    endfunction

    function automatic logic [CHAR_W-1:0] printable_char();
        logic [CHAR_W-1:0] c;
        begin
            c = CHAR_W'($urandom_range(0, 255));
            if (c == NEWLINE_CODE)
            begin
                c = SPACE_CODE;
            end
            return c;
        end
    endfunction

    function automatic logic [INDEX_W-1:0] any_index();
        return INDEX_W'($urandom_range(0, 2047));
    endfunction

    // Entered and left at a falling edge; start stays high when no gap follows.
    task automatic issue(input logic [OPCODE_W-1:0] op, input logic [CHAR_W-1:0] ch,
                         input logic [INDEX_W-1:0] idx, input logic typed,
                         input console_result_t want);
        console_result_t res;
        int              gap;
        begin
            start      = 1'b1;
            opcode     = op;
            char_code  = ch;
            cell_index = idx;
            do
            begin
                @(posedge clk);
            end
            while (busy);
            render_request(op, ch, idx, res);
            pending_results.push_back(typed ? want : res);
            issued_count++;
            @(negedge clk);
            gap = pick_gap();
            if (gap > 0)
            begin
                start = 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
    endtask

    task automatic set_color(input cfg_idx_t which, input logic [NIBBLE_W-1:0] value);
        begin
            cfg_valid = 1'b1;
            cfg_index = which;
            cfg_data  = value;
            do
            begin
                @(posedge clk);
            end
            while (!cfg_ready);
            if (which == CFG_FG)
            begin
                fg_nib = value;
            end
            else
            begin
                bg_nib = value;
            end
            @(negedge clk);
            cfg_valid = 1'b0;
        end
    endtask

    task automatic drain();
        begin
            start = 1'b0;
            while (pending_results.size() != 0)
            begin
                @(posedge clk);
            end
            repeat (20) @(posedge clk);
            @(negedge clk);
        end
    endtask

    task automatic random_traffic(input int n_items);
        int   first;
        int   kind;
        int   run;
        logic [INDEX_W-1:0] idx;
        begin
            first = issued_count;
            while (issued_count - first < n_items)
            begin
                kind = $urandom_range(0, 99);
                if (kind < 3)
                begin
                    // long line of text, usually past the margin
                    run = $urandom_range(70, 90);
                    repeat (run) issue(OP_PUT, printable_char(), any_index(), 1'b0, '0);
                end
                else if (kind < 6)
                begin
                    run = $urandom_range(1, 6);
                    repeat (run) issue(OP_PUT, NEWLINE_CODE, any_index(), 1'b0, '0);
                end
                else if (kind < 9)
                begin
                    // fill to the margin, then hit the pending wrap with a newline or a char
                    run = (cur_col < COLS) ? COLS - cur_col : 0;
                    repeat (run) issue(OP_PUT, printable_char(), any_index(), 1'b0, '0);
                    issue(OP_PUT, $urandom_range(0, 1) ? NEWLINE_CODE : printable_char(),
                          any_index(), 1'b0, '0);
                end
                else if (kind < 45)
                begin
                    issue(OP_PUT, ($urandom_range(0, 9) == 0) ? NEWLINE_CODE : 8'($urandom_range(0, 255)),
                          any_index(), 1'b0, '0);
                end
                else if (kind < 85)
                begin
                    run = $urandom_range(0, 99);
                    if (run < 55)
                    begin
                        idx = INDEX_W'($urandom_range(0, CELLS - 1));
                    end
                    else if (run < 85)
                    begin
                        idx = INDEX_W'(cur_line * COLS + int'($urandom_range(0, COLS - 1)));
                    end
                    else
                    begin
                        idx = INDEX_W'($urandom_range(CELLS, 2047));
                    end
                    issue(OP_READ, CHAR_W'($urandom_range(0, 255)), idx, 1'b0, '0);
                end
                else if (kind < 91)
                begin
                    issue(OP_CLEAR, CHAR_W'($urandom_range(0, 255)), any_index(), 1'b0, '0);
                end
                else
                begin
                    issue(OP_UNUSED, CHAR_W'($urandom_range(0, 255)), any_index(), 1'b0, '0);
                end
            end
        end
    endtask

    always @(posedge clk)
    begin
        console_result_t seen;
        console_result_t exp_res;
        if (rst_n && done)
        begin
            seen = '{cell_char, cell_color, cursor_row, cursor_col};
            if (pending_results.size() == 0)
            begin
                error_count++;
                if (error_count <= 200)
                begin
                    $display("%0t unexpected result: char %02h color %02h row %0d col %0d",
                             $time, seen.cell_char, seen.cell_color, seen.cursor_row,
                             seen.cursor_col);
                end
            end
            else
            begin
                exp_res = pending_results.pop_front();
                if (seen !== exp_res)
                begin
                    error_count++;
                    if (error_count <= 200)
                    begin
                        $display({"%0t mismatch: expected char %02h color %02h row %0d col %0d,",
                                  " got char %02h color %02h row %0d col %0d"},
                                 $time, exp_res.cell_char, exp_res.cell_color,
                                 exp_res.cursor_row, exp_res.cursor_col, seen.cell_char,
                                 seen.cell_color, seen.cursor_row, seen.cursor_col);
                    end
                end
            end
        end
    end

    initial
    begin
        // far beyond the slowest legal run (every request scrolling, every gap long)
        #(64'd300_000_000);
        $display("status: fail");
        $finish;
    end

    initial
    begin
        int i;
        int phase;
        rst_n        = 1'b0;
        start        = 1'b0;
        opcode       = OP_PUT;
        char_code    = '0;
        cell_index   = '0;
        cfg_valid    = 1'b0;
        cfg_index    = CFG_FG;
        cfg_data     = '0;
        error_count  = 0;
        issued_count = 0;
        gapless      = 1'b0;
        fg_nib       = RESET_FG;
        bg_nib       = RESET_BG;
        cur_line     = 0;
        cur_col      = 0;
        for (i = 0; i < LINES; i++)
        begin
            blank_line(i);
        end
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (i = 0; i < DIRECTED_ROWS; i++)
        begin
            issue(DIRECTED[i].op, DIRECTED[i].ch, DIRECTED[i].idx, DIRECTED[i].typed,
                  DIRECTED[i].want);
        end

        for (phase = 0; phase < 6; phase++)
        begin
            drain();
            case (phase)
                0:
                begin
                    set_color(CFG_FG, 4'h0);
                    set_color(CFG_BG, 4'hF);
                end
                1:
                begin
                    set_color(CFG_FG, 4'hF);
                    set_color(CFG_BG, 4'hF);
                end
                2:
                begin
                    set_color(CFG_FG, 4'h0);
                    set_color(CFG_BG, 4'h0);
                end
                5:
                begin
                    set_color(CFG_BG, RESET_BG);
                    set_color(CFG_FG, RESET_FG);
                end
                default:
                begin
                    set_color(CFG_FG, NIBBLE_W'($urandom_range(0, 15)));
                    set_color(CFG_BG, NIBBLE_W'($urandom_range(0, 15)));
                end
            endcase
            gapless = (phase == 2);
            random_traffic(240);
        end

        drain();
        if (error_count == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

FILE: text_console_writer_core.f
sv/tcw_pkg.sv
sv/tcw_screen_mem.sv
sv/tcw_ctrl.sv
sv/text_console_writer_core.sv
sv/tcw_checker.sv
tb/testbench.sv
